@@ design/sdes_pkg.sv @@
// ----------------------------------------------------------------------------
// sdes_pkg
// Shared types, constants and round function for the 12-bit feistel cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package sdes_pkg;

  localparam int unsigned Rounds    = 3;
  localparam int unsigned KeyBits   = 9;
  localparam int unsigned HalfBits  = 6;
  localparam int unsigned BlockBits = 2 * HalfBits;
  localparam int unsigned RkeyBits  = 8;

  typedef logic [HalfBits-1:0]  half_t;
  typedef logic [BlockBits-1:0] block_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [RkeyBits-1:0]  rkey_t;
  typedef logic [2:0]           sout_t;

  typedef struct packed {
    logic  valid;
    half_t left;
    half_t right;
  } stage_t;

  localparam sout_t SboxOne [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };

  localparam sout_t SboxTwo [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  function automatic rkey_t expand_half(half_t v);
    return {v[5], v[4], v[2], v[3], v[2], v[3], v[1], v[0]};
  endfunction

  function automatic half_t round_function(half_t half, rkey_t rkey);
    rkey_t x;
    x = expand_half(half) ^ rkey;
    return {SboxOne[x[7:4]], SboxTwo[x[3:0]]};
  endfunction

endpackage

`default_nettype wire

@@ design/sdes_key_sched.sv @@
// ----------------------------------------------------------------------------
// sdes_key_sched
// Key register and fixed bit rotation that forms every round key.
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_key_sched (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          cfg_we_i,
  input  wire sdes_pkg::key_t                                cfg_wdata_i,
  output sdes_pkg::key_t                                     key_o,
  output sdes_pkg::rkey_t [sdes_pkg::Rounds-1:0]             rkey_o
);

  sdes_pkg::key_t key_q, key_d;

  assign key_d = cfg_we_i ? cfg_wdata_i : key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

  // round r, bit j takes key bit (j - r) mod 9
  for (genvar r = 0; r < sdes_pkg::Rounds; r++) begin : g_round
    for (genvar j = 0; j < sdes_pkg::RkeyBits; j++) begin : g_bit
      localparam int unsigned Src =
        (j + sdes_pkg::KeyBits - (r % sdes_pkg::KeyBits)) % sdes_pkg::KeyBits;
      assign rkey_o[r][j] = key_q[Src];
    end
  end

endmodule

`default_nettype wire

@@ design/sdes_round.sv @@
// ----------------------------------------------------------------------------
// sdes_round
// One feistel round followed by its pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_round (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdes_pkg::stage_t stage_i,
  input  wire sdes_pkg::rkey_t  rkey_i,
  output sdes_pkg::stage_t      stage_o
);

  logic            valid_q, valid_d;
  sdes_pkg::half_t left_q, left_d;
  sdes_pkg::half_t right_q, right_d;

  assign valid_d = stage_i.valid;
  assign left_d  = stage_i.right;
  assign right_d = stage_i.left ^ sdes_pkg::round_function(stage_i.right, rkey_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload only moves with a valid item
  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign stage_o = '{valid: valid_q, left: left_q, right: right_q};

endmodule

`default_nettype wire

@@ design/simplified_des_encrypt.sv @@
// ----------------------------------------------------------------------------
// simplified_des_encrypt
// Pipelined 12-bit feistel encryptor with a 9-bit key register.
// ----------------------------------------------------------------------------
// usage
//   config: write the 9-bit key with cfg_we_i/cfg_wdata_i while no item is in
//   flight; the key register resets to zero.
//   input: an item is taken at each edge where start_i is high and busy_o is
//   low; busy_o stays low, so an item can be given in every cycle.
//   output: cipher_block_o is valid for the one cycle in which done_o is high;
//   the receiver cannot stall, results are never held back.
// pipeline and throughput
//   one pipeline register per round, so each result passes through every
//   round register in order, and one item per cycle is sustained.
//   the round logic is two xor levels and two 16-entry s-box lookups per stage.
// reset
//   rst_ni clears the key and every stage valid bit; items in flight are
//   dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module simplified_des_encrypt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [sdes_pkg::KeyBits-1:0]   cfg_wdata_i,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [sdes_pkg::BlockBits-1:0] plain_block_i,
  output logic                          done_o,
  output logic [sdes_pkg::BlockBits-1:0]      cipher_block_o
);

  sdes_pkg::key_t                        key;
  sdes_pkg::rkey_t [sdes_pkg::Rounds-1:0] rkey;
  sdes_pkg::stage_t                      stage [sdes_pkg::Rounds+1];

  assign busy_o = 1'b0;

  sdes_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key),
    .rkey_o      (rkey)
  );

  assign stage[0] = '{
    valid: start_i & ~busy_o,
    left:  plain_block_i[sdes_pkg::BlockBits-1:sdes_pkg::HalfBits],
    right: plain_block_i[sdes_pkg::HalfBits-1:0]
  };

  for (genvar r = 0; r < sdes_pkg::Rounds; r++) begin : g_round
    sdes_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[r]),
      .rkey_i  (rkey[r]),
      .stage_o (stage[r+1])
    );
  end

  assign done_o         = stage[sdes_pkg::Rounds].valid;
  assign cipher_block_o = {stage[sdes_pkg::Rounds].left, stage[sdes_pkg::Rounds].right};

`ifndef SYNTHESIS
  a_item_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(sdes_pkg::Rounds) done_o)
    else $error("accepted item did not complete");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, sdes_pkg::Rounds))
    else $error("result without an accepted item");

  a_first_rkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rkey[0] == key[sdes_pkg::RkeyBits-1:0])
    else $error("first round key does not match key");
`endif

endmodule

`default_nettype wire

@@ tb/tb_simplified_des_encrypt.sv @@
// ----------------------------------------------------------------------------
// tb_simplified_des_encrypt
// Self-checking bench for the 12-bit feistel encryptor. Each accepted block is
// enciphered by a local predictor under the current key. Each strobed result is
// compared with the oldest pending ciphertext. Directed corner blocks and keys
// come first, then random blocks under changing keys with varied issue gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_simplified_des_encrypt;

  localparam int unsigned Latency    = sdes_pkg::Rounds;
  localparam int unsigned CycleLimit = 200000;

  localparam logic [2:0] SubHi [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] SubLo [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  sdes_pkg::key_t   cfg_wdata_i   = '0;
  logic             start_i       = 1'b0;
  sdes_pkg::block_t plain_block_i = '0;
  logic             busy_o;
  logic             done_o;
  sdes_pkg::block_t cipher_block_o;

  sdes_pkg::block_t pending_cipher[$];
  sdes_pkg::block_t want_cipher;
  sdes_pkg::key_t   cur_key        = '0;
  int unsigned      idle_pct       = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      blocks_sent    = 0;
  int unsigned      blocks_checked = 0;
  int unsigned      keys_loaded    = 0;
  int unsigned      error_count    = 0;

  simplified_des_encrypt u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .plain_block_i  (plain_block_i),
    .done_o         (done_o),
    .cipher_block_o (cipher_block_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_simplified_des_encrypt NOT OK");
      $finish;
    end
  end

  function automatic sdes_pkg::block_t encipher(input sdes_pkg::key_t key,
                                                input sdes_pkg::block_t blk);
    sdes_pkg::half_t lh, rh, nx;
    sdes_pkg::rkey_t rk, ex;
    lh = blk[11:6];
    rh = blk[5:0];
    for (int r = 0; r < sdes_pkg::Rounds; r++) begin
      for (int j = 0; j < sdes_pkg::RkeyBits; j++)
        rk[j] = key[(j + sdes_pkg::KeyBits - r) % sdes_pkg::KeyBits];
      ex = {rh[5:4], rh[2], rh[3], rh[2], rh[3], rh[1:0]} ^ rk;
      nx = lh ^ {SubHi[ex[7:4]], SubLo[ex[3:0]]};
      lh = rh;
      rh = nx;
    end
    return {lh, rh};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_cipher.size() == 0) begin
        $error("cipher_block: no item pending, got %h", cipher_block_o);
        error_count++;
      end else begin
        want_cipher = pending_cipher.pop_front();
        blocks_checked++;
        if (cipher_block_o !== want_cipher) begin
          $error("cipher_block: expected %h, got %h", want_cipher, cipher_block_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_block(input sdes_pkg::block_t blk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    plain_block_i <= blk;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_cipher.push_back(encipher(cur_key, blk));
    blocks_sent++;
  endtask

  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic load_key(input sdes_pkg::key_t k);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_key  = k;
    keys_loaded++;
  endtask

  // corner blocks under the reset key and under extreme and sparse keys
  task automatic test_directed();
    send_block(12'h000);
    send_block(12'hFFF);
    send_block(12'hFC0);
    send_block(12'h03F);
    load_key(9'h1FF);
    send_block(12'h000);
    send_block(12'hFFF);
    send_block(12'hAAA);
    send_block(12'h555);
    load_key(9'h001);
    send_block(12'h800);
    send_block(12'h001);
    load_key(9'h100);
    send_block(12'h020);
    send_block(12'h7FF);
    load_key(9'h155);
    send_block(12'h0C3);
    send_block(12'hF3C);
    load_key(9'h0AA);
    send_block(12'h00C);
    send_block(12'h30C);
  endtask

  // random blocks, key changed every 50 items, issue gaps varied per phase
  task automatic test_random_phases();
    int unsigned pct[4] = '{0, 66, 0, 12};
    sdes_pkg::key_t k;
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      for (int s = 0; s < 3; s++) begin
        k = sdes_pkg::key_t'($urandom_range(511));
        if (s == 0 && p == 0) k = '0;
        if (s == 0 && p == 1) k = '1;
        load_key(k);
        for (int n = 0; n < 50; n++)
          send_block(sdes_pkg::block_t'($urandom_range(4095)));
      end
    end
    idle_pct = 0;
  endtask

  // full pause with the pipeline empty, then resume under the same key
  task automatic test_drain_and_resume();
    for (int n = 0; n < 10; n++) send_block(sdes_pkg::block_t'($urandom_range(4095)));
    drain_pipeline();
    for (int n = 0; n < 10; n++) send_block(sdes_pkg::block_t'($urandom_range(4095)));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_drain_and_resume();
    drain_pipeline();
    if (pending_cipher.size() != 0) begin
      $error("cipher_block: %0d items never returned", pending_cipher.size());
      error_count++;
    end
    $display("enciphered %0d blocks (%0d checked) under %0d loaded keys,",
             blocks_sent, blocks_checked, keys_loaded);
    $display("with back-to-back, sparse and paused issue");
    if (error_count == 0) begin
      $display("tb_simplified_des_encrypt OK");
    end else begin
      $display("tb_simplified_des_encrypt NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
